@@ hw/rtl/bhrw_pkg.sv @@
// Shared widths, register indexes, codes and types of the bucketed hit-rate window.
package bhrw_pkg;

    localparam int TIME_W   = 48;   // event timestamp
    localparam int BMS_W    = 32;   // bucket length register
    localparam int WIN_W    = 7;    // window size register
    localparam int CNT_W    = 32;   // per-bucket counters
    localparam int SUM_W    = 38;   // running sums
    localparam int RATE_W   = 17;   // Q1.16 rate, 65536 = 1.0
    localparam int QUAL_W   = 2;
    localparam int BCOUNT_W = 7;    // bucket_count output

    localparam int S_TDATA_W = 48;  // time_ms
    localparam int M_TDATA_W = 104; // 102 bits of fields, padded to bytes

    localparam int CFG_AW = 1;
    localparam int CFG_DW = 32;

    localparam int DEF_MAX_BUCKETS = 64;

    localparam logic [BMS_W-1:0] BUCKET_MS_RST = BMS_W'(1000);
    localparam logic [WIN_W-1:0] WINDOW_RST    = WIN_W'(10);

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_BUCKET_MS = 1'b0;
    localparam logic [CFG_AW-1:0] REG_WINDOW    = 1'b1;

    typedef enum logic [QUAL_W-1:0] {
        Q_POOR       = 2'd0,
        Q_ACCEPTABLE = 2'd1,
        Q_GOOD       = 2'd2,
        Q_EXCELLENT  = 2'd3
    } quality_t;

    // One stored bucket
    typedef struct packed {
        logic [TIME_W-1:0] index;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  total;
    } bucket_t;

    localparam int BUCKET_W = $bits(bucket_t);

endpackage

@@ hw/rtl/bucketed_hit_rate_window_core.sv @@
// Top level of the bucketed hit-rate window: event intake, bucket store and rate output.
//
// s_* stream: one item per detection event, s_tdata = 48-bit ms timestamp, s_tuser = hit.
// m_* stream: one result item per input item, in order: hit and event sums over the kept
//   buckets, Q1.16 hit rate (floor), quality class and bucket count; m_tuser flags an
//   out-of-order event that was ignored.
// Config port: index 0 bucket length in ms (0 acts as 1), index 1 window size in buckets
//   (clears the store and sums). Write only while the block is idle.
// Timing: one item at a time. From accept to result valid: a 48-step timestamp /
//   bucket-length division (the newest and oldest bucket RAM reads overlap it), a check
//   step (eviction), an update step (RAM write-back), a rate setup step, then, unless the
//   event sum is zero, a 17-step rate division on the shared bit-serial divider and one
//   to three quality compares. The next item can be taken in the cycle after the result
//   is loaded into the output register.
// Reset: aresetn (synchronous, active low) empties the window, zeroes the sums and
//   restores register defaults. No RAM clearing pass: only slots inside the window are used.
// Stall: a result waits in the output register while m_tready is low; the next item is
//   still accepted and computed and waits only at the output step.
module bucketed_hit_rate_window_core
    #(
    parameter int MAX_BUCKETS = bhrw_pkg::DEF_MAX_BUCKETS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bhrw_pkg::S_TDATA_W-1:0] s_tdata,   // [47:0] time_ms
    input  logic                           s_tuser,   // [0] hit
    // result item
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bhrw_pkg::M_TDATA_W-1:0] m_tdata,   // [37:0] sum_hits, [75:38] sum_total,
                                                      // [92:76] rate_q16, [94:93] quality,
                                                      // [101:95] bucket_count, [103:102] zero
    output logic                           m_tuser,   // [0] dropped
    // configuration
    input  logic                           cfg_we,
    input  logic [bhrw_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [bhrw_pkg::CFG_DW-1:0]    cfg_wdata
);

    import bhrw_pkg::*;

    localparam int SLOT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int FILL_W = $clog2(MAX_BUCKETS + 1);
    localparam int DIVC_W = $clog2(TIME_W + 1);
    localparam int QX_W   = SUM_W + 5;   // room for 20 * sum

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_NEW,
        S_RD_OLD,
        S_DIV_T,
        S_CHECK,
        S_UPDATE,
        S_RATE_GO,
        S_DIV_R,
        S_Q_HI,
        S_Q_MID,
        S_Q_LO,
        S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [BMS_W-1:0]  bucket_ms_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [FILL_W-1:0] win_eff;

    // window bookkeeping
    logic [SLOT_W-1:0] oldest_reg;
    logic [FILL_W-1:0] filled_reg;
    logic [SUM_W-1:0]  run_hits_reg;
    logic [SUM_W-1:0]  run_total_reg;

    // per-item work registers
    logic              hit_reg;
    logic              drop_reg;
    logic              new_reg;
    bucket_t           newest_ent_reg;
    bucket_t           oldest_ent_reg;
    logic [RATE_W-1:0] rate_reg;

    // output register
    logic                m_tvalid_reg;
    logic                m_drop_reg;
    logic [SUM_W-1:0]    m_hits_reg;
    logic [SUM_W-1:0]    m_total_reg;
    logic [RATE_W-1:0]   m_rate_reg;
    quality_t            m_qual_reg;
    logic [BCOUNT_W-1:0] m_count_reg;
    quality_t            qual_reg;

    // bucket RAM
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    bucket_t           ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    bucket_t           ram_rdata;

    // shared bit-serial divider
    logic              div_start;
    logic [SUM_W-1:0]  div_rem_init;
    logic [TIME_W-1:0] div_dsr_init;
    logic [SUM_W-1:0]  div_dvs_init;
    logic [DIVC_W-1:0] div_cnt_init;
    logic              div_busy_reg;
    logic [DIVC_W-1:0] div_cnt_reg;
    logic [SUM_W-1:0]  div_rem_reg;
    logic [TIME_W-1:0] div_dsr_reg;
    logic [SUM_W-1:0]  div_dvs_reg;
    logic [TIME_W-1:0] div_quo_reg;
    logic [SUM_W:0]    div_trial;
    logic              div_ge;
    logic [SUM_W-1:0]  div_rem_next;

    logic              s_fire;
    logic [SLOT_W-1:0] newest_slot;
    logic [SLOT_W-1:0] append_slot;
    logic [BMS_W-1:0]  bucket_len;
    logic [TIME_W-1:0] idx;
    logic              chk_has;
    logic              chk_drop;
    logic              chk_new;
    logic              chk_evict;
    bucket_t           upd_base;
    logic              upd_tot_inc;
    logic              upd_hit_inc;
    logic [QX_W-1:0]   q_lhs;
    logic [QX_W-1:0]   q_rhs;
    logic              q_ge;

    // (base + k) mod MAX_BUCKETS, base < MAX_BUCKETS and k <= MAX_BUCKETS
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [FILL_W-1:0] k);
        logic [FILL_W:0] s;
        s = (FILL_W + 1)'(base) + (FILL_W + 1)'(k);
        if (s >= (FILL_W + 1)'(MAX_BUCKETS)) begin
            s = s - (FILL_W + 1)'(MAX_BUCKETS);
        end
        return SLOT_W'(s);
    endfunction

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_drop_reg;
    assign m_tdata  = {2'b00, m_count_reg, m_qual_reg, m_rate_reg, m_total_reg, m_hits_reg};

    // window size 0 acts as 1, above MAX_BUCKETS as MAX_BUCKETS
    always_comb begin
        if (window_reg == '0) begin
            win_eff = FILL_W'(1);
        end else if (32'(window_reg) > 32'(MAX_BUCKETS)) begin
            win_eff = FILL_W'(MAX_BUCKETS);
        end else begin
            win_eff = FILL_W'(window_reg);
        end
    end

    assign bucket_len  = (bucket_ms_reg == '0) ? BMS_W'(1) : bucket_ms_reg;
    assign newest_slot = (filled_reg == '0) ? oldest_reg
                                            : slot_add(oldest_reg, filled_reg - FILL_W'(1));
    assign append_slot = slot_add(oldest_reg, filled_reg);
    assign idx         = div_quo_reg;

    // bucket decision
    assign chk_has   = (filled_reg != '0);
    assign chk_drop  = chk_has && (idx < newest_ent_reg.index);
    assign chk_new   = !chk_has || (idx != newest_ent_reg.index);
    assign chk_evict = !chk_drop && chk_new && (filled_reg >= win_eff);

    // counting into the newest bucket; counters stop at all ones
    assign upd_base    = new_reg ? bucket_t'{index: idx, hits: '0, total: '0} : newest_ent_reg;
    assign upd_tot_inc = (upd_base.total != '1);
    assign upd_hit_inc = hit_reg && (upd_base.hits != '1);

    // quality: 20h >= 17n, 5h >= 3n, 10h >= 3n, one per cycle
    always_comb begin
        unique case (state_reg)
            S_Q_HI: begin
                q_lhs = QX_W'({run_hits_reg, 4'b0}) + QX_W'({run_hits_reg, 2'b0});
                q_rhs = QX_W'({run_total_reg, 4'b0}) + QX_W'(run_total_reg);
            end
            S_Q_MID: begin
                q_lhs = QX_W'({run_hits_reg, 2'b0}) + QX_W'(run_hits_reg);
                q_rhs = QX_W'({run_total_reg, 1'b0}) + QX_W'(run_total_reg);
            end
            default: begin
                q_lhs = QX_W'({run_hits_reg, 3'b0}) + QX_W'({run_hits_reg, 1'b0});
                q_rhs = QX_W'({run_total_reg, 1'b0}) + QX_W'(run_total_reg);
            end
        endcase
    end
    assign q_ge = (q_lhs >= q_rhs);

    // RAM access and divider launch
    always_comb begin
        ram_re       = 1'b0;
        ram_raddr    = newest_slot;
        ram_we       = 1'b0;
        ram_waddr    = new_reg ? append_slot : newest_slot;
        ram_wdata    = upd_base;
        div_start    = 1'b0;
        div_rem_init = '0;
        div_dsr_init = s_tdata[TIME_W-1:0];
        div_dvs_init = SUM_W'(bucket_len);
        div_cnt_init = DIVC_W'(TIME_W);
        if (upd_tot_inc) begin
            ram_wdata.total = upd_base.total + CNT_W'(1);
        end
        if (upd_hit_inc) begin
            ram_wdata.hits = upd_base.hits + CNT_W'(1);
        end
        unique case (state_reg)
            S_IDLE: begin
                ram_re    = s_fire;
                div_start = s_fire;
            end
            S_RD_NEW: begin
                ram_re    = 1'b1;
                ram_raddr = oldest_reg;
            end
            S_UPDATE: begin
                ram_we = !drop_reg;
            end
            S_RATE_GO: begin
                // (h << 16) / n with h <= n: quotient fits 17 bits
                div_start    = (run_total_reg != '0);
                div_rem_init = run_hits_reg >> 1;
                div_dsr_init = {run_hits_reg[0], {(TIME_W - 1){1'b0}}};
                div_dvs_init = run_total_reg;
                div_cnt_init = DIVC_W'(RATE_W);
            end
            default: begin
            end
        endcase
    end

    bhrw_ram #(
        .WIDTH (BUCKET_W),
        .DEPTH (MAX_BUCKETS)
    ) u_bucket_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // restoring divider, one quotient bit per cycle
    assign div_trial    = {div_rem_reg, div_dsr_reg[TIME_W-1]};
    assign div_ge       = (div_trial >= {1'b0, div_dvs_reg});
    assign div_rem_next = div_ge ? SUM_W'(div_trial - {1'b0, div_dvs_reg})
                                 : div_trial[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (div_start) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= div_cnt_init;
            div_rem_reg  <= div_rem_init;
            div_dsr_reg  <= div_dsr_init;
            div_dvs_reg  <= div_dvs_init;
            div_quo_reg  <= '0;
        end else if (div_busy_reg) begin
            div_rem_reg  <= div_rem_next;
            div_dsr_reg  <= {div_dsr_reg[TIME_W-2:0], 1'b0};
            div_quo_reg  <= {div_quo_reg[TIME_W-2:0], div_ge};
            div_cnt_reg  <= div_cnt_reg - DIVC_W'(1);
            div_busy_reg <= (div_cnt_reg != DIVC_W'(1));
        end
    end

    // control, window state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            bucket_ms_reg <= BUCKET_MS_RST;
            window_reg    <= WINDOW_RST;
            oldest_reg    <= '0;
            filled_reg    <= '0;
            run_hits_reg  <= '0;
            run_total_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // the output step reloads the register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        hit_reg   <= s_tuser;
                        state_reg <= S_RD_NEW;
                    end
                end
                S_RD_NEW: begin
                    newest_ent_reg <= ram_rdata;
                    state_reg      <= S_RD_OLD;
                end
                S_RD_OLD: begin
                    oldest_ent_reg <= ram_rdata;
                    state_reg      <= S_DIV_T;
                end
                S_DIV_T: begin
                    if (!div_busy_reg) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    drop_reg <= chk_drop;
                    new_reg  <= chk_new;
                    if (chk_evict) begin
                        run_hits_reg  <= run_hits_reg - SUM_W'(oldest_ent_reg.hits);
                        run_total_reg <= run_total_reg - SUM_W'(oldest_ent_reg.total);
                        oldest_reg    <= slot_add(oldest_reg, FILL_W'(1));
                        filled_reg    <= filled_reg - FILL_W'(1);
                    end
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (!drop_reg) begin
                        if (new_reg) begin
                            filled_reg <= filled_reg + FILL_W'(1);
                        end
                        if (upd_tot_inc) begin
                            run_total_reg <= run_total_reg + SUM_W'(1);
                        end
                        if (upd_hit_inc) begin
                            run_hits_reg <= run_hits_reg + SUM_W'(1);
                        end
                    end
                    state_reg <= S_RATE_GO;
                end
                S_RATE_GO: begin
                    if (run_total_reg == '0) begin
                        rate_reg  <= '0;
                        qual_reg  <= Q_POOR;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_DIV_R;
                    end
                end
                S_DIV_R: begin
                    if (!div_busy_reg) begin
                        rate_reg  <= div_quo_reg[RATE_W-1:0];
                        state_reg <= S_Q_HI;
                    end
                end
                S_Q_HI: begin
                    if (q_ge) begin
                        qual_reg  <= Q_EXCELLENT;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_Q_MID;
                    end
                end
                S_Q_MID: begin
                    if (q_ge) begin
                        qual_reg  <= Q_GOOD;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_Q_LO;
                    end
                end
                S_Q_LO: begin
                    qual_reg  <= q_ge ? Q_ACCEPTABLE : Q_POOR;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // wait here only while the previous result is still held
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_drop_reg   <= drop_reg;
                        m_hits_reg   <= run_hits_reg;
                        m_total_reg  <= run_total_reg;
                        m_rate_reg   <= rate_reg;
                        m_qual_reg   <= qual_reg;
                        m_count_reg  <= BCOUNT_W'(filled_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            // the user is to write registers only while idle; the block itself does not enforce it
            if (cfg_we) begin
                if (cfg_addr == REG_BUCKET_MS) begin
                    bucket_ms_reg <= cfg_wdata[BMS_W-1:0];
                end else if (cfg_addr == REG_WINDOW) begin
                    window_reg    <= cfg_wdata[WIN_W-1:0];
                    oldest_reg    <= '0;
                    filled_reg    <= '0;
                    run_hits_reg  <= '0;
                    run_total_reg <= '0;
                end
            end
        end
    end

    // window never holds more buckets than allowed
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= win_eff)
        else $error("bucket count above window size");

    // hits can never outrun events, bucket by bucket and so in the sums
    a_hits_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        run_hits_reg <= run_total_reg)
        else $error("running hits above running total");

    // empty window holds no counts
    a_empty_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        (filled_reg == '0) |-> (run_total_reg == '0))
        else $error("nonzero sums with empty window");

    // rate never above 1.0 in a delivered result
    a_rate_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_rate_reg <= RATE_W'(65536)))
        else $error("rate above 1.0");

endmodule

@@ hw/rtl/bhrw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bhrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ tb/bhrw_window_checker.sv @@
// Checker for the bucketed hit-rate window: mirrors the bucket store and compares every result.
`timescale 1ns / 100ps

module bhrw_window_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bhrw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bhrw_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tuser,
    input  logic                           cfg_we,
    input  logic [bhrw_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [bhrw_pkg::CFG_DW-1:0]    cfg_wdata,
    output int unsigned                    fail_count,
    output int unsigned                    pending
);

    import bhrw_pkg::*;

    localparam int NBUCKETS   = DEF_MAX_BUCKETS;
    localparam int EXP_DEPTH  = 64;    // far above the two items the block can hold
    localparam int HITS_LSB   = 0;
    localparam int TOTAL_LSB  = HITS_LSB + SUM_W;
    localparam int RATE_LSB   = TOTAL_LSB + SUM_W;
    localparam int QUAL_LSB   = RATE_LSB + RATE_W;
    localparam int BCOUNT_LSB = QUAL_LSB + QUAL_W;

    typedef struct packed {
        logic                dropped;
        logic [SUM_W-1:0]    sum_hits;
        logic [SUM_W-1:0]    sum_total;
        logic [RATE_W-1:0]   rate_q16;
        quality_t            quality;
        logic [BCOUNT_W-1:0] bucket_count;
    } window_result_t;

    // expected results, in order of acceptance
    window_result_t    exp_fifo[EXP_DEPTH];
    int unsigned       exp_rd;
    int unsigned       exp_wr;

    logic [TIME_W-1:0] idx_mem[NBUCKETS];
    logic [CNT_W-1:0]  hit_mem[NBUCKETS];
    logic [CNT_W-1:0]  tot_mem[NBUCKETS];
    int                oldest;
    int                filled;
    logic [SUM_W-1:0]  run_hits;
    logic [SUM_W-1:0]  run_total;
    logic [BMS_W-1:0]  bucket_len;
    logic [WIN_W-1:0]  window_reg;
    int unsigned       result_no;

    function automatic int eff_window();
        int w;
        w = int'(window_reg);
        if (w == 0) w = 1;
        if (w > NBUCKETS) w = NBUCKETS;
        return w;
    endfunction

    task automatic clear_window();
        oldest    = 0;
        filled    = 0;
        run_hits  = '0;
        run_total = '0;
    endtask

    task automatic predict_window(input logic hit, input logic [TIME_W-1:0] t,
                                  output window_result_t r);
        longint unsigned len;
        longint unsigned idx;
        longint unsigned hh;
        longint unsigned nn;
        int              newest;
        logic            drop;
        len  = (bucket_len == '0) ? 64'd1 : 64'(bucket_len);
        idx  = 64'(t) / len;
        drop = 1'b0;
        if (filled > 0) begin
            newest = (oldest + filled - 1) % NBUCKETS;
            if (idx < 64'(idx_mem[newest])) drop = 1'b1;
        end
        if (!drop) begin
            if (filled == 0 || idx != 64'(idx_mem[(oldest + filled - 1) % NBUCKETS])) begin
                // new bucket; evict the oldest when the window is full
                if (filled >= eff_window()) begin
                    run_hits  = run_hits - SUM_W'(hit_mem[oldest]);
                    run_total = run_total - SUM_W'(tot_mem[oldest]);
                    oldest    = (oldest + 1) % NBUCKETS;
                    filled    = filled - 1;
                end
                newest          = (oldest + filled) % NBUCKETS;
                idx_mem[newest] = idx[TIME_W-1:0];
                hit_mem[newest] = '0;
                tot_mem[newest] = '0;
                filled          = filled + 1;
            end
            newest = (oldest + filled - 1) % NBUCKETS;
            if (tot_mem[newest] != '1) begin
                tot_mem[newest] = tot_mem[newest] + CNT_W'(1);
                run_total       = run_total + SUM_W'(1);
            end
            if (hit && hit_mem[newest] != '1) begin
                hit_mem[newest] = hit_mem[newest] + CNT_W'(1);
                run_hits        = run_hits + SUM_W'(1);
            end
        end
        hh             = 64'(run_hits);
        nn             = 64'(run_total);
        r.dropped      = drop;
        r.sum_hits     = run_hits;
        r.sum_total    = run_total;
        r.bucket_count = BCOUNT_W'(filled);
        if (nn == 0) begin
            r.rate_q16 = '0;
            r.quality  = Q_POOR;
        end else begin
            r.rate_q16 = RATE_W'((hh << 16) / nn);
            if (20 * hh >= 17 * nn)      r.quality = Q_EXCELLENT;
            else if (5 * hh >= 3 * nn)   r.quality = Q_GOOD;
            else if (10 * hh >= 3 * nn)  r.quality = Q_ACCEPTABLE;
            else                         r.quality = Q_POOR;
        end
    endtask

    always @(posedge aclk) begin
        window_result_t exp_r;
        window_result_t got_r;
        if (!aresetn) begin
            clear_window();
            bucket_len = BUCKET_MS_RST;
            window_reg = WINDOW_RST;
            exp_rd     = 0;
            exp_wr     = 0;
            result_no  = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_BUCKET_MS: begin
                        bucket_len = cfg_wdata[BMS_W-1:0];
                    end
                    REG_WINDOW: begin
                        window_reg = cfg_wdata[WIN_W-1:0];
                        clear_window();
                    end
                    default: ;
                endcase
            end
            // result side first: a result never belongs to the item taken in the same cycle
            if (m_tvalid && m_tready) begin
                got_r.dropped      = m_tuser;
                got_r.sum_hits     = m_tdata[HITS_LSB +: SUM_W];
                got_r.sum_total    = m_tdata[TOTAL_LSB +: SUM_W];
                got_r.rate_q16     = m_tdata[RATE_LSB +: RATE_W];
                got_r.quality      = quality_t'(m_tdata[QUAL_LSB +: QUAL_W]);
                got_r.bucket_count = m_tdata[BCOUNT_LSB +: BCOUNT_W];
                if (exp_wr == exp_rd) begin
                    if (fail_count < 10)
                        $display("result %0d: no item pending, got drop=%0d hits=%0d tot=%0d",
                                 result_no, got_r.dropped, got_r.sum_hits, got_r.sum_total);
                    fail_count = fail_count + 1;
                end else begin
                    exp_r  = exp_fifo[exp_rd % EXP_DEPTH];
                    exp_rd = exp_rd + 1;
                    if (got_r !== exp_r) begin
                        if (fail_count < 10) begin
                            $display({"result %0d exp: drop=%0d hits=%0d tot=%0d",
                                      " rate=%0d q=%0d n=%0d"},
                                     result_no, exp_r.dropped, exp_r.sum_hits, exp_r.sum_total,
                                     exp_r.rate_q16, exp_r.quality, exp_r.bucket_count);
                            $display({"result %0d got: drop=%0d hits=%0d tot=%0d",
                                      " rate=%0d q=%0d n=%0d"},
                                     result_no, got_r.dropped, got_r.sum_hits, got_r.sum_total,
                                     got_r.rate_q16, got_r.quality, got_r.bucket_count);
                        end
                        fail_count = fail_count + 1;
                    end
                end
                result_no = result_no + 1;
            end
            if (s_tvalid && s_tready) begin
                predict_window(s_tuser, s_tdata[TIME_W-1:0], exp_r);
                exp_fifo[exp_wr % EXP_DEPTH] = exp_r;
                exp_wr                       = exp_wr + 1;
            end
        end
        pending = exp_wr - exp_rd;
    end

endmodule

@@ tb/bucketed_hit_rate_window_core_test.sv @@
// Testbench top of the bucketed hit-rate window: stimulus, handshake idling and the verdict.
`timescale 1ns / 100ps

module bucketed_hit_rate_window_core_test;
    import bhrw_pkg::*;

    // Cycles without any item moving before the run is declared hung.
    localparam int QUIET_LIMIT  = 5000;
    localparam int SEGMENTS     = 9;
    localparam int SEG_ITEMS    = 172;     // in-order items per random segment
    localparam int DRAIN_TAIL   = 100;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [47:0] time_ms
    logic                 s_tuser   = 1'b0; // [0] hit
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [37:0] sum_hits, [75:38] sum_total,
                                            // [92:76] rate_q16, [94:93] quality,
                                            // [101:95] bucket_count, [103:102] zero
    logic                 m_tuser;          // [0] dropped
    logic                 cfg_we    = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr  = '0;
    logic [CFG_DW-1:0]    cfg_wdata = '0;

    int unsigned          fail_count;
    int unsigned          pending;

    // idle percentages of the sender and the receiver
    int                   s_idle_pct = 37;
    int                   m_idle_pct = 58;

    // event-time generator state
    longint unsigned      cur_ms;
    logic [BMS_W-1:0]     cur_len;
    int                   hit_pct;
    int unsigned          quiet_cycles = 0;

    bucketed_hit_rate_window_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    bhrw_window_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 aclk = ~aclk;

    // Receiver: random per-cycle stalls of m_tready.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Present one item, with random idle cycles first. s_tready is read at the
    // falling edge, where it is settled for the coming rising edge. Returns just
    // after the accepting edge with s_tvalid still high, so a back-to-back item
    // replaces the data without a second update of s_tvalid in the same step.
    task automatic send_item(input logic hit, input logic [TIME_W-1:0] t);
        bit taken;
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        s_tuser  <= hit;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
    endtask

    // Stop sending and wait for every expected result; the block is then idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // One register write; the enable drops in its own cycle afterwards.
    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Next event time. Mostly a rising sequence (same bucket, next bucket or a
    // jump over a gap), sometimes a step back or a random earlier time, which
    // the block drops when it falls before the newest bucket. in_order marks the rising ones.
    task automatic next_event(output logic [TIME_W-1:0] t, output bit in_order);
        longint unsigned len;
        longint unsigned step;
        longint unsigned back;
        int unsigned     span;
        int              kind;
        len      = (cur_len == '0) ? 64'd1 : 64'(cur_len);
        span     = 32'(len - 1);
        kind     = $urandom_range(0, 99);
        in_order = 1'b1;
        step     = 0;
        if (kind < 45) begin
            step = 64'($urandom_range(0, span >> 2));
        end else if (kind < 80) begin
            step = len + 64'($urandom_range(0, span));
        end else if (kind < 90) begin
            step = len * 64'($urandom_range(2, 100));
        end else begin
            in_order = 1'b0;
        end
        if (in_order) begin
            cur_ms = (64'(TIME_MAX) - cur_ms < step) ? 64'(TIME_MAX) : cur_ms + step;
            t      = cur_ms[TIME_W-1:0];
        end else if (kind < 96) begin
            back = len * 64'($urandom_range(1, 3));
            t    = (cur_ms > back) ? TIME_W'(cur_ms - back) : '0;
        end else begin
            t = TIME_W'({$urandom(), $urandom()} % (cur_ms + 1));
        end
    endtask

    initial begin
        logic [BMS_W-1:0]  bms;
        logic [WIN_W-1:0]  win;
        logic [TIME_W-1:0] t;
        bit                in_order;
        bit                len_changed;
        int                counted;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: reset defaults (1000 ms, 10 buckets). Same bucket, next
        // bucket, out-of-order drop, the largest timestamp, then a drop of 0.
        send_item(1'b0, '0);
        send_item(1'b1, TIME_W'(999));
        send_item(1'b1, TIME_W'(1000));
        send_item(1'b0, TIME_W'(500));
        send_item(1'b1, TIME_MAX);
        send_item(1'b0, '0);
        drain();

        // Window 0 behaves as one bucket, length 0 as 1 ms: each new ms evicts.
        cfg_write(REG_WINDOW, '0);
        cfg_write(REG_BUCKET_MS, '0);
        send_item(1'b1, TIME_W'(5));
        send_item(1'b0, TIME_W'(6));
        send_item(1'b1, TIME_W'(4));
        drain();

        // Window above the maximum; one bucket of 20 events walks the rate
        // down to exactly 0.60 (3 of 5) and then up to exactly 0.85 (17 of 20).
        cfg_write(REG_WINDOW, CFG_DW'(127));
        cfg_write(REG_BUCKET_MS, BMS_W'(3));
        for (int i = 0; i < 20; i++) begin
            send_item(!(i == 3 || i == 4 || i == 19), TIME_W'(i % 3));
        end
        drain();

        // Random segments, each with its own setting; idling mode changes
        // every three segments: sender-light, receiver-light, then none.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 3)
                0: begin
                    s_idle_pct = 37;
                    m_idle_pct = 58;
                end
                1: begin
                    s_idle_pct = 58;
                    m_idle_pct = 37;
                end
                default: begin
                    s_idle_pct = 0;
                    m_idle_pct = 0;
                end
            endcase
            case (seg)
                0: begin bms = BMS_W'(1);     win = WIN_W'(1);   hit_pct = 50; end
                1: begin bms = '0;            win = WIN_W'(64);  hit_pct = 85; end
                2: begin bms = BMS_W'(7);     win = WIN_W'(3);   hit_pct = 60; end
                3: begin bms = 32'hFFFF_FFFF; win = WIN_W'(127); hit_pct = 30; end
                4: begin bms = BMS_W'(1);     win = WIN_W'(127); hit_pct = 90; end
                5: begin
                    bms     = $urandom_range(1, 50);
                    win     = WIN_W'($urandom_range(1, 64));
                    hit_pct = $urandom_range(0, 100);
                end
                6: begin bms = BMS_W'(1000);  win = '0;          hit_pct = 70; end
                7: begin
                    bms     = $urandom();
                    win     = WIN_W'($urandom_range(0, 127));
                    hit_pct = 50;
                end
                default: begin bms = BMS_W'(250); win = WIN_W'(2); hit_pct = 15; end
            endcase
            // upper data bits of the window write are don't-care; keep them random
            cfg_write(REG_WINDOW, ($urandom() & ~CFG_DW'(8'h7F)) | CFG_DW'(win));
            cfg_write(REG_BUCKET_MS, bms);
            cur_len = bms;
            cur_ms  = {18'b0, 14'($urandom_range(0, 16383)), 32'($urandom())};

            counted     = 0;
            len_changed = 1'b0;
            while (counted < SEG_ITEMS) begin
                if (!len_changed && counted == SEG_ITEMS / 2) begin
                    // mid-segment length change keeps the buckets; shorter
                    // lengths raise the index, longer ones make drops for a while
                    drain();
                    cur_len = (seg % 2) ? (cur_len << 1) : ((cur_len >> 1) + BMS_W'(1));
                    cfg_write(REG_BUCKET_MS, cur_len);
                    len_changed = 1'b1;
                end
                next_event(t, in_order);
                send_item($urandom_range(0, 99) < hit_pct, t);
                if (in_order) counted++;
            end
            drain();
        end

        repeat (DRAIN_TAIL) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ bucketed_hit_rate_window_core.f @@
hw/rtl/bhrw_pkg.sv
hw/rtl/bhrw_ram.sv
hw/rtl/bucketed_hit_rate_window_core.sv
tb/bhrw_window_checker.sv
tb/bucketed_hit_rate_window_core_test.sv
